/* rtl/mfmu_pkg.sv */
// Shared types and constants for the motor feedback multiturn unwrap block.
package mfmu_pkg;

  typedef logic signed [15:0] angle_t;
  typedef logic signed [16:0] cur_t;
  typedef logic signed [18:0] step_t;
  typedef logic [31:0]        total_t;
  typedef logic [2:0]         motor_sel_t;

  localparam logic [10:0] ID_BASE  = 11'h200;
  localparam logic [10:0] ID_FIRST = 11'h201;
  localparam logic [10:0] ID_LAST  = 11'h205;

  localparam motor_sel_t MOTOR_NONE = 3'd0;
  localparam motor_sel_t MOTOR_FIVE = 3'd5;

  localparam logic [14:0] THRESH_RESET = 15'd1000;

  localparam int NUM_UNWRAP  = 4;
  localparam int NUM_CAPTURE = 2;

endpackage

/* rtl/mfmu_unwrap.sv */
// One motor's unwrap step: the shorter of the raw delta and the wrapped delta.
module mfmu_unwrap #(
  parameter int COUNTS_PER_TURN = 8192
) (
  input  mfmu_pkg::cur_t  cur,
  input  mfmu_pkg::cur_t  prev,
  output mfmu_pkg::step_t step
);
  import mfmu_pkg::*;

  localparam step_t Turn = step_t'(COUNTS_PER_TURN);

  step_t       raw;
  step_t       wrap;
  logic [18:0] raw_mag;
  logic [18:0] wrap_mag;

  always_comb begin
    raw      = step_t'(cur) - step_t'(prev);
    wrap     = (prev > cur) ? raw + Turn : raw - Turn;
    raw_mag  = raw[18] ? 19'(-raw) : 19'(raw);
    wrap_mag = wrap[18] ? 19'(-wrap) : 19'(wrap);
    step     = (wrap_mag > raw_mag) ? raw : wrap;
  end

endmodule

/* rtl/motor_feedback_multiturn_unwrap_core.sv */
// Top level of the motor feedback multiturn unwrap block.
//
// Each input beat carries one received CAN frame. Identifiers 0x201 to 0x204
// update the angles of motors one to four and 0x205 updates motor five, whose
// temperature byte is kept. Every frame unwraps the four stored angles into
// 32-bit running totals and produces exactly one output beat.
// The input beat is first captured in an input register. From there the
// decode, the four unwrap units and the total adders run and the result is
// loaded into the output register once the output register is empty or is
// being read out. One beat is accepted per cycle
// when the receiver keeps out_tready high; the throughput is set by the single
// stage of unwrap and add logic between the state registers.
// When the receiver stalls, the output beat holds and the input register can
// still take one more beat, after which in_tready drops.
// The synchronous reset clears all stored angles, offsets and totals and sets
// the capture threshold to 1000. The threshold is written through the cfg_
// port, which is always ready, and should be written only while idle.
module motor_feedback_multiturn_unwrap_core #(
  parameter int COUNTS_PER_TURN = 8192
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // frame_id[10:0], angle_word[26:11], speed_word[42:27], temp_byte[50:43]
  input  logic [55:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // total_one[31:0], total_two[63:32], total_three[95:64], total_four[127:96],
  // motor_speed[143:128], motor_temp[151:144]
  output logic [151:0] out_tdata,
  // matched_motor[2:0]
  output logic [2:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [14:0]  cfg_data
);
  import mfmu_pkg::*;

  logic        cfg_write;
  logic [14:0] thresh_r;

  logic        s1_valid_r;
  logic [10:0] s1_id_r;
  angle_t      s1_angle_r;
  angle_t      s1_speed_r;
  logic [7:0]  s1_temp_r;

  angle_t      ang_r    [NUM_UNWRAP];
  angle_t      ang_nxt  [NUM_UNWRAP];
  angle_t      offset_r [NUM_CAPTURE];
  cur_t        prev_r   [NUM_UNWRAP];
  cur_t        cur      [NUM_UNWRAP];
  step_t       step     [NUM_UNWRAP];
  total_t      total_r  [NUM_UNWRAP];
  total_t      total_nxt[NUM_UNWRAP];
  logic        capture  [NUM_CAPTURE];
  logic [7:0]  temp_r;

  logic        out_valid_r;
  motor_sel_t  out_match_r;
  angle_t      out_speed_r;

  logic        advance;
  logic        in_accept;
  logic        hit;
  motor_sel_t  match;

  assign cfg_write = cfg_valid & cfg_ready;
  assign cfg_ready = 1'b1;

  assign advance   = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | advance;
  assign in_accept = in_tvalid & in_tready;

  always_comb begin
    hit   = (s1_id_r >= ID_FIRST) && (s1_id_r <= ID_LAST);
    match = hit ? 3'(s1_id_r - ID_BASE) : MOTOR_NONE;
  end

  for (genvar k = 0; k < NUM_UNWRAP; k++) begin : g_motor
    always_comb begin
      ang_nxt[k] = (hit && (match == 3'(k + 1))) ? s1_angle_r : ang_r[k];
      if (k < NUM_CAPTURE) begin
        cur[k] = {ang_nxt[k][15], ang_nxt[k]} -
                 {offset_r[k % NUM_CAPTURE][15], offset_r[k % NUM_CAPTURE]};
      end else begin
        cur[k] = {ang_nxt[k][15], ang_nxt[k]};
      end
      total_nxt[k] = total_r[k] + {{13{step[k][18]}}, step[k]};
    end

    mfmu_unwrap #(
      .COUNTS_PER_TURN(COUNTS_PER_TURN)
    ) u_unwrap (
      .cur  (cur[k]),
      .prev (prev_r[k]),
      .step (step[k])
    );
  end

  for (genvar c = 0; c < NUM_CAPTURE; c++) begin : g_capture
    assign capture[c] = (offset_r[c] == '0) &&
                        ($signed(ang_nxt[c]) > $signed({1'b0, thresh_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_write) begin
      thresh_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_id_r    <= in_tdata[10:0];
      s1_angle_r <= in_tdata[26:11];
      s1_speed_r <= in_tdata[42:27];
      s1_temp_r  <= in_tdata[50:43];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_UNWRAP; i++) begin
        ang_r[i]   <= '0;
        prev_r[i]  <= '0;
        total_r[i] <= '0;
      end
      for (int i = 0; i < NUM_CAPTURE; i++) begin
        offset_r[i] <= '0;
      end
      temp_r <= '0;
    end else if (advance) begin
      for (int i = 0; i < NUM_UNWRAP; i++) begin
        ang_r[i]   <= ang_nxt[i];
        prev_r[i]  <= cur[i];
        total_r[i] <= total_nxt[i];
      end
      for (int i = 0; i < NUM_CAPTURE; i++) begin
        if (capture[i]) begin
          offset_r[i] <= ang_nxt[i];
        end
      end
      if (match == MOTOR_FIVE) begin
        temp_r <= s1_temp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_match_r <= match;
      out_speed_r <= hit ? s1_speed_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_match_r;
  assign out_tdata  = {temp_r, out_speed_r, total_r[3], total_r[2], total_r[1], total_r[0]};

  a_match_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_match_r <= MOTOR_FIVE))
    else $error("matched motor out of range");

  a_speed_unmatched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_match_r == MOTOR_NONE)) |-> (out_speed_r == '0))
    else $error("speed not zero for an unmatched frame");

  a_offset_once: assert property (@(posedge clk) disable iff (!rst_n)
    (offset_r[0] != '0) |=> $stable(offset_r[0]))
    else $error("motor one offset changed after capture");

  a_offset_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (offset_r[1] != '0) |-> !offset_r[1][15])
    else $error("motor two offset captured as negative");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipeline");

endmodule
